/* rtl/gpf_pkg.sv */
// Shared types, constants and the microcode program of the polynomial fitness block.
package gpf_pkg;

  localparam int DEFAULT_MAX_TERMS = 16;
  localparam int TERM_CODE_W       = 20;
  localparam int TERM_INDEX_W      = 4;
  localparam int TERM_COUNT_W      = 5;
  localparam int X_W               = 16;
  localparam int DATA_W            = 32;
  localparam int SCORE_W           = 14;
  localparam int TOTAL_W           = 40;

  localparam logic [TERM_COUNT_W-1:0] TERM_COUNT_RESET = 5'd4;
  localparam logic [SCORE_W-1:0]      SCORE_MAX        = 14'd10000;

  // Request codes carried on req_type.
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_EVAL = 1'b1;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_CLEAR,
    OP_LOADTERM,
    OP_POWSTEP,
    OP_TERMMUL,
    OP_ACCUM,
    OP_DIST,
    OP_FINISH
  } dp_op_t;

  typedef enum logic [2:0] {
    C_NONE,
    C_ALWAYS,
    C_IDLE_WAIT,
    C_N_ZERO,
    C_POW_MORE,
    C_MORE_TERMS
  } cond_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'd0,
    ST_INIT  = 4'd1,
    ST_FETCH = 4'd2,
    ST_LOAD  = 4'd3,
    ST_POW   = 4'd4,
    ST_TERM  = 4'd5,
    ST_ACC   = 4'd6,
    ST_SCORE = 4'd7,
    ST_DONE  = 4'd8
  } step_t;

  typedef struct packed {
    dp_op_t op;
    cond_t  cond;
    step_t  target;
  } ucode_t;

  // Control handed from the sequencer to the datapath.
  typedef struct packed {
    dp_op_t op;
    logic   busy;
  } ctrl_t;

  // Flags the datapath returns for conditional jumps.
  typedef struct packed {
    logic n_zero;
    logic pow_more;
    logic more_terms;
  } status_t;

  // The program: a jump is taken when its condition holds, otherwise the
  // counter moves to the following step.
  function automatic ucode_t ucode_rom(input step_t s);
    ucode_t w;
    case (s)
      ST_IDLE:  w = '{op: OP_NOP,      cond: C_IDLE_WAIT,  target: ST_IDLE};
      ST_INIT:  w = '{op: OP_CLEAR,    cond: C_N_ZERO,     target: ST_SCORE};
      ST_FETCH: w = '{op: OP_NOP,      cond: C_NONE,       target: ST_IDLE};
      ST_LOAD:  w = '{op: OP_LOADTERM, cond: C_NONE,       target: ST_IDLE};
      ST_POW:   w = '{op: OP_POWSTEP,  cond: C_POW_MORE,   target: ST_POW};
      ST_TERM:  w = '{op: OP_TERMMUL,  cond: C_NONE,       target: ST_IDLE};
      ST_ACC:   w = '{op: OP_ACCUM,    cond: C_MORE_TERMS, target: ST_FETCH};
      ST_SCORE: w = '{op: OP_DIST,     cond: C_NONE,       target: ST_IDLE};
      ST_DONE:  w = '{op: OP_FINISH,   cond: C_ALWAYS,     target: ST_IDLE};
      default:  w = '{op: OP_NOP,      cond: C_ALWAYS,     target: ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

/* rtl/gpf_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module gpf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/gpf_ucode.sv */
// Microcode sequencer: step counter, program table and jump logic.
module gpf_ucode (
  input  logic             clk,
  input  logic             rst,
  input  logic             go,
  input  gpf_pkg::status_t status,
  output gpf_pkg::ctrl_t   ctrl
);
  import gpf_pkg::*;

  step_t  step;
  step_t  step_next;
  ucode_t word;
  logic   take;

  assign word = ucode_rom(step);

  always_comb begin
    case (word.cond)
      C_NONE:       take = 1'b0;
      C_ALWAYS:     take = 1'b1;
      C_IDLE_WAIT:  take = !go;
      C_N_ZERO:     take = status.n_zero;
      C_POW_MORE:   take = status.pow_more;
      C_MORE_TERMS: take = status.more_terms;
      default:      take = 1'b1;
    endcase
    step_next = take ? word.target : step_t'(step + 4'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_IDLE;
    end else begin
      step <= step_next;
    end
  end

  assign ctrl.op   = word.op;
  assign ctrl.busy = (step != ST_IDLE);

endmodule

/* rtl/gpf_datapath.sv */
// Datapath: term decode, shared multiplier, accumulator and scoring.
module gpf_datapath #(
  parameter int MAX_TERMS = gpf_pkg::DEFAULT_MAX_TERMS
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  gpf_pkg::ctrl_t                                ctrl,
  input  logic                                          go,
  input  logic signed [gpf_pkg::X_W-1:0]                x_in,
  input  logic signed [gpf_pkg::DATA_W-1:0]             y_in,
  input  logic                                          first_in,
  input  logic [gpf_pkg::TERM_COUNT_W-1:0]              term_count,
  input  logic [gpf_pkg::TERM_CODE_W-1:0]               rd_data,
  output logic [$clog2(MAX_TERMS > 1 ? MAX_TERMS : 2)-1:0] rd_addr,
  output gpf_pkg::status_t                              status,
  output logic                                          done,
  output logic signed [gpf_pkg::DATA_W-1:0]             poly_value,
  output logic [gpf_pkg::SCORE_W-1:0]                   sample_score,
  output logic [gpf_pkg::TOTAL_W-1:0]                   score_total
);
  import gpf_pkg::*;

  localparam int AW = $clog2(MAX_TERMS > 1 ? MAX_TERMS : 2);
  localparam int NW = $clog2(MAX_TERMS + 1);

  logic signed [X_W-1:0]    x_reg;
  logic signed [DATA_W-1:0] y_reg;
  logic                     first_reg;
  logic [AW-1:0]            k;
  logic [AW-1:0]            j;
  logic [DATA_W-1:0]        inner;
  logic [DATA_W-1:0]        pw;
  logic [11:0]              coef;
  logic [1:0]               sgn;
  logic [DATA_W-1:0]        prod;
  logic [DATA_W-1:0]        acc;
  logic [DATA_W:0]          distance;

  logic [NW-1:0]            n;
  logic [DATA_W-1:0]        x_ext;
  logic [DATA_W-1:0]        offs_ext;
  logic [DATA_W-1:0]        mul_b;
  logic [DATA_W-1:0]        mul_lo;
  logic [DATA_W:0]          diff;
  logic [SCORE_W-1:0]       score_c;
  logic [TOTAL_W:0]         sum;
  logic [TOTAL_W-1:0]       total_next;

  always_comb begin
    if (32'(term_count) > MAX_TERMS) begin
      n = NW'(MAX_TERMS);
    end else begin
      n = NW'(term_count);
    end
  end

  assign status.n_zero     = (n == '0);
  assign status.pow_more   = (j != k);
  assign status.more_terms = ((NW'(k) + NW'(1)) < n);
  assign rd_addr           = k;

  assign x_ext    = {{(DATA_W-X_W){x_reg[X_W-1]}}, x_reg};
  assign offs_ext = {26'd0, rd_data[17:12]};

  // One multiplier serves both the power steps and the coefficient product.
  assign mul_b  = (ctrl.op == OP_TERMMUL) ? {20'd0, coef} : inner;
  assign mul_lo = pw * mul_b;

  // The distance is taken one bit wider so that it never wraps.
  assign diff = {y_reg[DATA_W-1], y_reg} - {acc[DATA_W-1], acc};

  assign score_c = (distance > 33'(SCORE_MAX)) ? '0 : SCORE_MAX - distance[SCORE_W-1:0];
  assign sum     = {1'b0, score_total} + (TOTAL_W+1)'(score_c);

  always_comb begin
    if (first_reg) begin
      total_next = TOTAL_W'(score_c);
    end else if (sum[TOTAL_W]) begin
      total_next = '1;
    end else begin
      total_next = sum[TOTAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      x_reg     <= x_in;
      y_reg     <= y_in;
      first_reg <= first_in;
    end
    case (ctrl.op)
      OP_CLEAR: begin
        acc <= '0;
        k   <= '0;
      end
      OP_LOADTERM: begin
        sgn   <= rd_data[19:18];
        coef  <= rd_data[11:0];
        inner <= rd_data[18] ? x_ext - offs_ext : x_ext + offs_ext;
        pw    <= 32'd1;
        j     <= '0;
      end
      OP_POWSTEP: begin
        if (j != k) begin
          pw <= mul_lo;
          j  <= j + AW'(1);
        end
      end
      OP_TERMMUL: begin
        prod <= mul_lo;
      end
      OP_ACCUM: begin
        acc <= sgn[1] ? acc - prod : acc + prod;
        k   <= k + AW'(1);
      end
      OP_DIST: begin
        distance <= diff[DATA_W] ? -diff : diff;
      end
      OP_FINISH: begin
        poly_value   <= acc;
        sample_score <= score_c;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done        <= 1'b0;
      score_total <= '0;
    end else begin
      done <= (ctrl.op == OP_FINISH);
      if (ctrl.op == OP_FINISH) begin
        score_total <= total_next;
      end
    end
  end

endmodule

/* rtl/genome_polynomial_fitness.sv */
// Top level of the genome polynomial fitness scorer.
//
//  Channel   Direction  Handshake             Payload
//  request   in         start while !busy     req_type, term_index, term_code,
//                                             x_value, y_target, first_sample
//  result    out        done, one cycle       poly_value, sample_score, score_total
//  config    in         cfg_write             cfg_data (term_count)
//
// A load transaction writes the term store in the cycle it is accepted and
// leaves busy low, so a new request may follow in the next cycle.
// An evaluate transaction keeps busy high while it runs, its length set by n,
// the effective term count; the result strobe rises at the same edge at which
// busy falls. The length is set by the power loop on the single shared
// multiplier: term k takes k multiply steps plus one for its coefficient.
// Reset clears the sequencer, the result strobe and the running score total,
// and restores term_count to four; the term store holds no reset value.
// The receiver cannot stall: each result is shown for exactly one cycle.
module genome_polynomial_fitness #(
  parameter int MAX_TERMS = gpf_pkg::DEFAULT_MAX_TERMS
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic                                   req_type,
  input  logic [gpf_pkg::TERM_INDEX_W-1:0]       term_index,
  input  logic [gpf_pkg::TERM_CODE_W-1:0]        term_code,
  input  logic signed [gpf_pkg::X_W-1:0]         x_value,
  input  logic signed [gpf_pkg::DATA_W-1:0]      y_target,
  input  logic                                   first_sample,
  output logic                                   done,
  output logic signed [gpf_pkg::DATA_W-1:0]      poly_value,
  output logic [gpf_pkg::SCORE_W-1:0]            sample_score,
  output logic [gpf_pkg::TOTAL_W-1:0]            score_total,
  input  logic                                   cfg_write,
  input  logic [gpf_pkg::TERM_COUNT_W-1:0]       cfg_data
);
  import gpf_pkg::*;

  localparam int AW = $clog2(MAX_TERMS > 1 ? MAX_TERMS : 2);

  logic [TERM_COUNT_W-1:0] term_count;
  logic                    accept;
  logic                    go;
  logic                    load_we;
  logic [AW-1:0]           rd_addr;
  logic [TERM_CODE_W-1:0]  rd_data;
  ctrl_t                   ctrl;
  status_t                 status;

  // The single configuration register; the user must write it only while the block is idle, which it does not enforce.
  always_ff @(posedge clk) begin
    if (rst) begin
      term_count <= TERM_COUNT_RESET;
    end else if (cfg_write) begin
      term_count <= cfg_data;
    end
  end

  assign accept = start && !busy;
  assign go     = accept && (req_type == REQ_EVAL);

  // Loads beyond the store are dropped.
  assign load_we = accept && (req_type == REQ_LOAD) && (32'(term_index) < MAX_TERMS);

  gpf_ram #(
    .WIDTH (TERM_CODE_W),
    .DEPTH (MAX_TERMS)
  ) u_term_store (
    .clk   (clk),
    .we    (load_we),
    .waddr (AW'(term_index)),
    .wdata (term_code),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  gpf_ucode u_ucode (
    .clk    (clk),
    .rst    (rst),
    .go     (go),
    .status (status),
    .ctrl   (ctrl)
  );

  gpf_datapath #(
    .MAX_TERMS (MAX_TERMS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .go           (go),
    .x_in         (x_value),
    .y_in         (y_target),
    .first_in     (first_sample),
    .term_count   (term_count),
    .rd_data      (rd_data),
    .rd_addr      (rd_addr),
    .status       (status),
    .done         (done),
    .poly_value   (poly_value),
    .sample_score (sample_score),
    .score_total  (score_total)
  );

  assign busy = ctrl.busy;

`ifndef ASSERT_OFF
  // A result only ever closes an evaluation that was running in the previous cycle.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a running evaluation");

  // The sequencer leaves idle only for an accepted evaluate transaction.
  a_busy_from_eval: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start && req_type == REQ_EVAL))
    else $error("sequencer started without an evaluate transaction");

  // A score never exceeds the ceiling.
  a_score_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (sample_score <= SCORE_MAX))
    else $error("sample score above ceiling");

  // The running total moves only when a result is delivered.
  a_total_hold: assert property (@(posedge clk) disable iff (rst)
    !done |=> (done || $stable(score_total)))
    else $error("score total changed without a result");
`endif

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the genome polynomial fitness scorer.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import gpf_pkg::*;

  localparam int RESET_CYCLES    = 8;
  localparam int RANDOM_REQUESTS = 800;
  // Quiet cycles required before a term_count write. Loads finish in the
  // cycle they are accepted, so a few cycles is ample margin.
  localparam int SETTLE_CYCLES   = 4;
  // Cycles watched after the last result for a stray strobe.
  localparam int DRAIN_CYCLES    = 32;
  localparam int CYCLE_LIMIT     = 1_000_000;

  // The top letter of a term word picks the two signs: A adds both times,
  // B subtracts the offset, C subtracts the term, D subtracts both.
  typedef enum logic [1:0] {LETTER_A, LETTER_B, LETTER_C, LETTER_D} sign_letter_t;

  typedef enum logic {ITEM_REQUEST, ITEM_TERM_COUNT} item_kind_t;

  // One entry of the stimulus plan: either a request transaction or a
  // term_count register write. Fields a request does not use carry noise.
  typedef struct packed {
    item_kind_t                kind;
    logic                      req;
    logic [TERM_INDEX_W-1:0]   idx;
    logic [TERM_CODE_W-1:0]    code;
    logic [X_W-1:0]            x;
    logic [DATA_W-1:0]         y;
    logic                      restart;
    logic [TERM_COUNT_W-1:0]   count;
  } stimulus_item_t;

  typedef struct packed {
    logic [DATA_W-1:0]  poly_value;
    logic [SCORE_W-1:0] sample_score;
    logic [TOTAL_W-1:0] score_total;
  } score_result_t;

  typedef logic [DEFAULT_MAX_TERMS-1:0][TERM_CODE_W-1:0] term_bank_t;

  // Clock, reset and the block's inputs, all known from time zero.
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic req_type = 1'b0;
  logic [TERM_INDEX_W-1:0] term_index = '0;
  logic [TERM_CODE_W-1:0] term_code = '0;
  logic signed [X_W-1:0] x_value = '0;
  logic signed [DATA_W-1:0] y_target = '0;
  logic first_sample = 1'b0;
  logic cfg_write = 1'b0;
  logic [TERM_COUNT_W-1:0] cfg_data = '0;

  logic busy;
  logic done;
  logic signed [DATA_W-1:0] poly_value;
  logic [SCORE_W-1:0] sample_score;
  logic [TOTAL_W-1:0] score_total;

  always #2 clk = ~clk;

  genome_polynomial_fitness DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req_type     (req_type),
    .term_index   (term_index),
    .term_code    (term_code),
    .x_value      (x_value),
    .y_target     (y_target),
    .first_sample (first_sample),
    .done         (done),
    .poly_value   (poly_value),
    .sample_score (sample_score),
    .score_total  (score_total),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data)
  );

  // Work still to be driven, and the scores the block owes us, oldest first.
  stimulus_item_t request_queue[$];
  score_result_t  awaited_scores[$];

  // Shadow genome kept while planning, so evaluates only touch written slots
  // and targets can be placed near the true polynomial value.
  term_bank_t               plan_bank;
  logic [DEFAULT_MAX_TERMS-1:0] plan_written = '0;
  logic [TERM_COUNT_W-1:0]  plan_count = TERM_COUNT_RESET;
  int                       planned_requests = 0;

  // Predictor state, advanced in the order the block accepts transactions.
  term_bank_t               model_bank;
  logic [TERM_COUNT_W-1:0]  model_count = TERM_COUNT_RESET;
  logic [TOTAL_W-1:0]       model_total = '0;

  // Driver bookkeeping.
  stimulus_item_t current_item;
  logic           holding = 1'b0;
  logic           no_idle = 1'b0;
  int             gap = 0;
  int             quiet = 0;
  int             items_done = 0;
  int             total_items = 0;

  int failures = 0;
  int cycles = 0;

  function automatic logic [TERM_CODE_W-1:0] term_word(sign_letter_t letter,
                                                       logic [5:0] offs,
                                                       logic [11:0] coef);
    return {letter, offs, coef};
  endfunction

  // Sum of +/-coef * (x +/- offset)^k over the active terms, every operation
  // wrapping at 32 bits. Term zero always contributes its bare coefficient,
  // even when its base works out to zero.
  function automatic logic [DATA_W-1:0] poly_at(term_bank_t bank,
                                                logic [TERM_COUNT_W-1:0] count,
                                                logic [X_W-1:0] x);
    logic [DATA_W-1:0] sum;
    logic [DATA_W-1:0] xw;
    logic [DATA_W-1:0] base;
    logic [DATA_W-1:0] pw;
    sign_letter_t      letter;
    int                n;
    sum = '0;
    xw = {{(DATA_W-X_W){x[X_W-1]}}, x};
    n = (count > DEFAULT_MAX_TERMS) ? DEFAULT_MAX_TERMS : int'(count);
    for (int k = 0; k < n; k++) begin
      letter = sign_letter_t'(bank[k][19:18]);
      if (letter == LETTER_B || letter == LETTER_D) begin
        base = xw - DATA_W'(bank[k][17:12]);
      end else begin
        base = xw + DATA_W'(bank[k][17:12]);
      end
      pw = DATA_W'(1);
      for (int i = 0; i < k; i++) begin
        pw = pw * base;
      end
      pw = pw * DATA_W'(bank[k][11:0]);
      if (letter == LETTER_C || letter == LETTER_D) begin
        sum = sum - pw;
      end else begin
        sum = sum + pw;
      end
    end
    return sum;
  endfunction

  function automatic void plan_load(logic [TERM_INDEX_W-1:0] idx,
                                    logic [TERM_CODE_W-1:0] code);
    stimulus_item_t it;
    it.kind = ITEM_REQUEST;
    it.req = REQ_LOAD;
    it.idx = idx;
    it.code = code;
    it.x = X_W'($urandom);
    it.y = $urandom;
    it.restart = 1'($urandom);
    it.count = TERM_COUNT_W'($urandom);
    request_queue.push_back(it);
    plan_bank[idx] = code;
    plan_written[idx] = 1'b1;
    planned_requests++;
  endfunction

  function automatic void plan_eval(logic [X_W-1:0] x, logic [DATA_W-1:0] y,
                                    logic restart);
    stimulus_item_t it;
    it.kind = ITEM_REQUEST;
    it.req = REQ_EVAL;
    it.idx = TERM_INDEX_W'($urandom);
    it.code = TERM_CODE_W'($urandom);
    it.x = x;
    it.y = y;
    it.restart = restart;
    it.count = TERM_COUNT_W'($urandom);
    request_queue.push_back(it);
    planned_requests++;
  endfunction

  function automatic void plan_term_count(logic [TERM_COUNT_W-1:0] count);
    stimulus_item_t it;
    it = '0;
    it.kind = ITEM_TERM_COUNT;
    it.count = count;
    request_queue.push_back(it);
    plan_count = count;
  endfunction

  // Driver. Everything that happened at this edge is handed to the predictor
  // first: a register write that was on the port, or a request transaction
  // accepted because start was high while busy was low. Then the next step is
  // chosen and each port gets at most one nonblocking update.
  always @(posedge clk) begin : driver
    logic              drive_start;
    logic              drive_cfg;
    stimulus_item_t    head;
    score_result_t     result;
    longint            distance;
    longint            score;
    logic [TOTAL_W:0]  sum;
    int                r;
    if (rst) begin
      start <= 1'b0;
      cfg_write <= 1'b0;
    end else begin
      drive_start = 1'b0;
      drive_cfg = 1'b0;

      if (cfg_write) begin
        model_count = cfg_data;
        items_done++;
      end

      if (start && !busy) begin
        if (current_item.req == REQ_LOAD) begin
          model_bank[current_item.idx] = current_item.code;
        end else begin
          result.poly_value = poly_at(model_bank, model_count, current_item.x);
          // The distance is taken on exact integers, so a target and a value
          // on opposite ends of the 32-bit range score zero.
          distance = longint'($signed(current_item.y)) -
                     longint'($signed(result.poly_value));
          if (distance < 0) begin
            distance = -distance;
          end
          score = (distance > longint'(SCORE_MAX)) ? 0 : longint'(SCORE_MAX) - distance;
          if (current_item.restart) begin
            sum = (TOTAL_W+1)'(score);
          end else begin
            sum = {1'b0, model_total} + (TOTAL_W+1)'(score);
          end
          model_total = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
          result.sample_score = SCORE_W'(score);
          result.score_total = model_total;
          awaited_scores.push_back(result);
        end
        items_done++;
        holding = 1'b0;
        // Occasionally switch to a run of back-to-back transactions.
        if ($urandom_range(0, 49) == 0) begin
          no_idle = !no_idle;
        end
        // Gaps: mostly none or short, some medium, a few long enough to let
        // the block fall idle and sit there.
        r = $urandom_range(0, 99);
        if (no_idle || r < 50) begin
          gap = 0;
        end else if (r < 85) begin
          gap = $urandom_range(1, 3);
        end else if (r < 97) begin
          gap = $urandom_range(4, 20);
        end else begin
          gap = $urandom_range(30, 90);
        end
      end

      if (busy || start || cfg_write) begin
        quiet = 0;
      end else if (quiet < SETTLE_CYCLES) begin
        quiet++;
      end

      if (holding) begin
        // Still waiting for the block to take the current request.
        drive_start = 1'b1;
      end else if (gap > 0) begin
        gap--;
      end else if (request_queue.size() != 0) begin
        head = request_queue[0];
        if (head.kind == ITEM_REQUEST) begin
          head = request_queue.pop_front();
          current_item = head;
          holding = 1'b1;
          drive_start = 1'b1;
          req_type <= head.req;
          term_index <= head.idx;
          term_code <= head.code;
          x_value <= head.x;
          y_target <= head.y;
          first_sample <= head.restart;
        end else if (awaited_scores.size() == 0 && !busy && !cfg_write &&
                     quiet >= SETTLE_CYCLES) begin
          // term_count only changes with nothing in flight.
          head = request_queue.pop_front();
          cfg_data <= head.count;
          drive_cfg = 1'b1;
        end
      end

      start <= drive_start;
      cfg_write <= drive_cfg;
    end
  end

  // Monitor. A result is valid for the one cycle that done is high and is
  // taken at the edge that closes that cycle.
  always @(posedge clk) begin : monitor
    score_result_t want;
    if (!rst && done) begin
      if (awaited_scores.size() == 0) begin
        $error("unexpected result transaction: poly_value %0d, sample_score %0d",
               poly_value, sample_score);
        failures++;
      end else begin
        want = awaited_scores.pop_front();
        if (poly_value !== want.poly_value) begin
          $error("poly_value: expected %0d, actual %0d",
                 $signed(want.poly_value), poly_value);
          failures++;
        end
        if (sample_score !== want.sample_score) begin
          $error("sample_score: expected %0d, actual %0d",
                 want.sample_score, sample_score);
          failures++;
        end
        if (score_total !== want.score_total) begin
          $error("score_total: expected %0d, actual %0d",
                 want.score_total, score_total);
          failures++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin : watchdog
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin : stimulus
    int                       phase;
    int                       len;
    int                       r;
    int                       delta;
    int                       random_base;
    logic [X_W-1:0]           x;
    logic [DATA_W-1:0]        value;
    logic [DATA_W-1:0]        y;
    logic [TERM_COUNT_W-1:0]  c;

    // Directed part. The reset term count of four is used first, so slots
    // zero to three are loaded before anything is evaluated. Slot zero is
    // built so that x = 5 cancels its offset: a zero base raised to power
    // zero must still count as one.
    plan_load(0, term_word(LETTER_B, 6'd5, 12'd7));
    plan_load(1, term_word(LETTER_C, 6'd63, 12'd4095));
    plan_load(2, term_word(LETTER_D, 6'h2A, 12'hABC));
    plan_load(3, term_word(LETTER_A, 6'd0, 12'd0));
    x = 16'd5;
    plan_eval(x, poly_at(plan_bank, plan_count, x), 1'b1);
    x = 16'h8000;
    plan_eval(x, poly_at(plan_bank, plan_count, x) + 32'd10000, 1'b0);
    x = 16'h7FFF;
    plan_eval(x, poly_at(plan_bank, plan_count, x) - 32'd9999, 1'b0);
    plan_eval(16'd0, $urandom, 1'b0);

    // With no terms the value is zero; check both ends of the score range.
    plan_term_count(5'd0);
    plan_eval(X_W'($urandom), 32'd10000, 1'b1);
    plan_eval(X_W'($urandom), 32'd0, 1'b0);

    // Three terms that make 1 + 4x + 2x^2. At x = 32767 this is exactly
    // 2^31 - 1, so a target of -2^31 is one apart only after wrapping and
    // must score zero. At x = -32768 the square term wraps.
    plan_term_count(5'd3);
    plan_load(0, term_word(LETTER_A, 6'd0, 12'd1));
    plan_load(1, term_word(LETTER_A, 6'd0, 12'd4));
    plan_load(2, term_word(LETTER_A, 6'd0, 12'd2));
    plan_eval(16'h7FFF, 32'h8000_0000, 1'b1);
    x = 16'h7FFF;
    plan_eval(x, poly_at(plan_bank, plan_count, x), 1'b0);
    x = 16'h8000;
    plan_eval(x, poly_at(plan_bank, plan_count, x) - 32'd10001, 1'b0);
    plan_load(15, 20'hFFFFF);
    plan_load(0, 20'h00000);
    plan_eval(16'h1234, 32'h7FFF_FFFF, 1'b0);

    // Random phases, each under its own term count. Every slot the phase
    // reads is loaded before its first evaluate.
    random_base = planned_requests;
    phase = 0;
    while (planned_requests - random_base < RANDOM_REQUESTS) begin
      if (phase == 0) begin
        c = 5'd16;
      end else if (phase == 1) begin
        c = 5'd31;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          c = 5'd0;
        end else if (r < 18) begin
          c = 5'd1;
        end else if (r < 26) begin
          c = 5'd16;
        end else if (r < 34) begin
          c = TERM_COUNT_W'($urandom_range(17, 31));
        end else if (r < 44) begin
          c = TERM_COUNT_W'($urandom_range(7, 15));
        end else begin
          c = TERM_COUNT_W'($urandom_range(2, 6));
        end
      end
      plan_term_count(c);
      for (int k = 0; k < DEFAULT_MAX_TERMS; k++) begin
        if (k < c && !plan_written[k]) begin
          plan_load(k, TERM_CODE_W'($urandom));
        end
      end

      len = $urandom_range(8, 50);
      repeat (len) begin
        if ($urandom_range(0, 99) < 25) begin
          plan_load(TERM_INDEX_W'($urandom), TERM_CODE_W'($urandom));
        end else begin
          // Mostly small abscissas, where offsets can cancel, plus the
          // extremes and the full range.
          r = $urandom_range(0, 99);
          if (r < 50) begin
            x = X_W'($urandom_range(0, 128));
            x = x - 16'd64;
          end else if (r < 53) begin
            x = 16'h8000;
          end else if (r < 56) begin
            x = 16'h7FFF;
          end else begin
            x = X_W'($urandom);
          end
          // Targets sit on, near or at the edge of the scoring window, or
          // anywhere; the sum wraps, so values near the ends of the range
          // produce targets on the far side.
          value = poly_at(plan_bank, plan_count, x);
          r = $urandom_range(0, 99);
          if (r < 10) begin
            y = value;
          end else if (r < 22) begin
            case ($urandom_range(0, 5))
              0: delta = 10000;
              1: delta = -10000;
              2: delta = 10001;
              3: delta = -10001;
              4: delta = 9999;
              default: delta = -9999;
            endcase
            y = value + delta;
          end else if (r < 80) begin
            delta = int'($urandom_range(0, 21000)) - 10500;
            y = value + delta;
          end else begin
            y = $urandom;
          end
          plan_eval(x, y, $urandom_range(0, 7) == 0);
        end
      end
      phase++;
    end
    total_items = request_queue.size();

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    while (items_done < total_items || awaited_scores.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* genome_polynomial_fitness.f */
rtl/gpf_pkg.sv
rtl/gpf_ram.sv
rtl/gpf_ucode.sv
rtl/gpf_datapath.sv
rtl/genome_polynomial_fitness.sv
tb/testbench.sv
